FILE: rtl/assert_macros.svh
// assertion macros used by spring_tear_proximity_test.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define CHK_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/stp_pkg.sv
// widths, stage control and datapath types for the spring tear proximity test
// no dependencies
package stp_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W  = 25;
   localparam int PROD_W  = 50;
   localparam int XD_W    = 51;
   localparam int SUM_W   = 50;
   localparam int DOT_W   = 52;
   localparam int RAD_W   = 23;
   localparam int RSQ_W   = 46;
   localparam int HALF_W  = 25;
   localparam int RHALF_W = 23;
   localparam int RP_W    = 48;
   localparam int WIDE_W  = 102;
   localparam int IDX_W   = 12;
   localparam int STAGES  = 6;

   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;
   localparam logic REG_TEAR_RADIUS = 1'b0;
   localparam logic [RAD_W-1:0] TEAR_RADIUS_RESET = 23'd6554;

   typedef struct packed {
      logic [STAGES-1:0] adv;
   } stage_en_type;

   typedef struct packed {
      logic [SUM_W-1:0]          dist_a;
      logic [SUM_W-1:0]          dist_b;
      logic [SUM_W-1:0]          len_sq;
      logic signed [DOT_W-1:0]   dot;
      logic [2:0][PROD_W-1:0]    cross_mag;
      logic [RSQ_W-1:0]          rad_sq;
   } geom_type;

endpackage

FILE: rtl/stp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module stp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/stp_geom.sv
// first three pipeline stages: differences, 25x25 products, sums and cross magnitudes
// depends on stp_pkg
module stp_geom import stp_pkg::*; (
   input  logic                     clock,
   input  stage_en_type             stage_en,
   input  logic [2:0][COORD_W-1:0]  c_pos,
   input  logic [2:0][COORD_W-1:0]  a_pos,
   input  logic [2:0][COORD_W-1:0]  b_pos,
   input  logic [RAD_W-1:0]         tear_radius,
   output geom_type                 geom
);

   logic signed [DIFF_W-1:0] w_ff [3];
   logic signed [DIFF_W-1:0] d_ff [3];
   logic signed [DIFF_W-1:0] e_ff [3];
   logic signed [DIFF_W-1:0] w_in [3];
   logic signed [DIFF_W-1:0] d_in [3];
   logic signed [DIFF_W-1:0] e_in [3];

   logic signed [PROD_W-1:0] ww_ff [3];
   logic signed [PROD_W-1:0] ee_ff [3];
   logic signed [PROD_W-1:0] dd_ff [3];
   logic signed [PROD_W-1:0] wd_ff [3];
   logic signed [PROD_W-1:0] xm_ff [3];
   logic signed [PROD_W-1:0] xn_ff [3];
   logic [RSQ_W-1:0]         rsq_ff;

   logic signed [PROD_W-1:0] ww_in [3];
   logic signed [PROD_W-1:0] ee_in [3];
   logic signed [PROD_W-1:0] dd_in [3];
   logic signed [PROD_W-1:0] wd_in [3];
   logic signed [PROD_W-1:0] xm_in [3];
   logic signed [PROD_W-1:0] xn_in [3];
   logic [RSQ_W-1:0]         rsq_in;

   geom_type                 geom_ff;
   geom_type                 geom_in;
   logic signed [XD_W-1:0]   xd [3];
   logic signed [XD_W-1:0]   xd_abs [3];

   // stage 1: coordinate differences
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w_in[i] = DIFF_W'($signed(c_pos[i])) - DIFF_W'($signed(a_pos[i]));
         d_in[i] = DIFF_W'($signed(b_pos[i])) - DIFF_W'($signed(a_pos[i]));
         e_in[i] = DIFF_W'($signed(c_pos[i])) - DIFF_W'($signed(b_pos[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.adv[0]) begin
         w_ff <= w_in;
         d_ff <= d_in;
         e_ff <= e_in;
      end
   end

   // stage 2: all narrow products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ww_in[i] = PROD_W'(w_ff[i]) * PROD_W'(w_ff[i]);
         ee_in[i] = PROD_W'(e_ff[i]) * PROD_W'(e_ff[i]);
         dd_in[i] = PROD_W'(d_ff[i]) * PROD_W'(d_ff[i]);
         wd_in[i] = PROD_W'(w_ff[i]) * PROD_W'(d_ff[i]);
      end
      xm_in[0] = PROD_W'(w_ff[1]) * PROD_W'(d_ff[2]);
      xn_in[0] = PROD_W'(w_ff[2]) * PROD_W'(d_ff[1]);
      xm_in[1] = PROD_W'(w_ff[2]) * PROD_W'(d_ff[0]);
      xn_in[1] = PROD_W'(w_ff[0]) * PROD_W'(d_ff[2]);
      xm_in[2] = PROD_W'(w_ff[0]) * PROD_W'(d_ff[1]);
      xn_in[2] = PROD_W'(w_ff[1]) * PROD_W'(d_ff[0]);
      rsq_in   = RSQ_W'(tear_radius) * RSQ_W'(tear_radius);
   end

   always_ff @(posedge clock) begin
      if (stage_en.adv[1]) begin
         ww_ff  <= ww_in;
         ee_ff  <= ee_in;
         dd_ff  <= dd_in;
         wd_ff  <= wd_in;
         xm_ff  <= xm_in;
         xn_ff  <= xn_in;
         rsq_ff <= rsq_in;
      end
   end

   // stage 3: sums of squares, dot product and cross product magnitudes
   always_comb begin
      geom_in.dist_a = SUM_W'($unsigned(ww_ff[0])) + SUM_W'($unsigned(ww_ff[1]))
                     + SUM_W'($unsigned(ww_ff[2]));
      geom_in.dist_b = SUM_W'($unsigned(ee_ff[0])) + SUM_W'($unsigned(ee_ff[1]))
                     + SUM_W'($unsigned(ee_ff[2]));
      geom_in.len_sq = SUM_W'($unsigned(dd_ff[0])) + SUM_W'($unsigned(dd_ff[1]))
                     + SUM_W'($unsigned(dd_ff[2]));
      geom_in.dot    = DOT_W'(wd_ff[0]) + DOT_W'(wd_ff[1]) + DOT_W'(wd_ff[2]);
      for (int i = 0; i < 3; i++) begin
         xd[i]     = XD_W'(xm_ff[i]) - XD_W'(xn_ff[i]);
         xd_abs[i] = xd[i][XD_W-1] ? -xd[i] : xd[i];
         geom_in.cross_mag[i] = xd_abs[i][PROD_W-1:0];
      end
      geom_in.rad_sq = rsq_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en.adv[2]) begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;

endmodule

FILE: rtl/stp_wide.sv
// last three pipeline stages: endpoint and segment conditions, split wide squares,
// the 102-bit sums and the final squared-distance compare
// depends on stp_pkg
module stp_wide import stp_pkg::*; (
   input  logic         clock,
   input  stage_en_type stage_en,
   input  geom_type     geom,
   output logic         cut
);

   // stage 4 registers
   logic                  hit4_ff, seg4_ff;
   logic [PROD_W-1:0]     hh4_ff [3];
   logic [PROD_W-1:0]     hl4_ff [3];
   logic [PROD_W-1:0]     ll4_ff [3];
   logic [RP_W-1:0]       rhh4_ff, rhl4_ff, rlh4_ff, rll4_ff;
   logic                  hit4_in, seg4_in;
   logic [PROD_W-1:0]     hh4_in [3];
   logic [PROD_W-1:0]     hl4_in [3];
   logic [PROD_W-1:0]     ll4_in [3];
   logic [RP_W-1:0]       rhh4_in, rhl4_in, rlh4_in, rll4_in;
   logic [HALF_W-1:0]     xh, xl;

   // stage 5 registers
   logic                  hit5_ff, seg5_ff;
   logic [WIDE_W-1:0]     sq5_ff [3];
   logic [WIDE_W-1:0]     rhs5_ff;
   logic [WIDE_W-1:0]     sq5_in [3];
   logic [WIDE_W-1:0]     rhs5_in;

   // stage 6 registers
   logic                  hit6_ff, seg6_ff;
   logic [WIDE_W-1:0]     lhs6_ff, rhs6_ff;
   logic [WIDE_W-1:0]     lhs6_in;

   always_comb begin
      hit4_in = (geom.dist_a < SUM_W'(geom.rad_sq)) || (geom.dist_b < SUM_W'(geom.rad_sq));
      // projection strictly inside the segment, else the closest point is an endpoint
      seg4_in = (geom.len_sq != '0) && (geom.dot > DOT_W'(0))
                && (geom.dot < $signed(DOT_W'(geom.len_sq)));
      for (int i = 0; i < 3; i++) begin
         xh = geom.cross_mag[i][PROD_W-1:HALF_W];
         xl = geom.cross_mag[i][HALF_W-1:0];
         hh4_in[i] = PROD_W'(xh) * PROD_W'(xh);
         hl4_in[i] = PROD_W'(xh) * PROD_W'(xl);
         ll4_in[i] = PROD_W'(xl) * PROD_W'(xl);
      end
      rhh4_in = RP_W'(geom.rad_sq[RSQ_W-1:RHALF_W]) * RP_W'(geom.len_sq[SUM_W-1:HALF_W]);
      rhl4_in = RP_W'(geom.rad_sq[RSQ_W-1:RHALF_W]) * RP_W'(geom.len_sq[HALF_W-1:0]);
      rlh4_in = RP_W'(geom.rad_sq[RHALF_W-1:0]) * RP_W'(geom.len_sq[SUM_W-1:HALF_W]);
      rll4_in = RP_W'(geom.rad_sq[RHALF_W-1:0]) * RP_W'(geom.len_sq[HALF_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (stage_en.adv[3]) begin
         hit4_ff <= hit4_in;
         seg4_ff <= seg4_in;
         hh4_ff  <= hh4_in;
         hl4_ff  <= hl4_in;
         ll4_ff  <= ll4_in;
         rhh4_ff <= rhh4_in;
         rhl4_ff <= rhl4_in;
         rlh4_ff <= rlh4_in;
         rll4_ff <= rll4_in;
      end
   end

   // stage 5: reassemble each square and the radius term from partial products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq5_in[i] = (WIDE_W'(hh4_ff[i]) << (2 * HALF_W))
                   + (WIDE_W'(hl4_ff[i]) << (HALF_W + 1))
                   + WIDE_W'(ll4_ff[i]);
      end
      rhs5_in = (WIDE_W'(rhh4_ff) << (RHALF_W + HALF_W))
              + (WIDE_W'(rhl4_ff) << RHALF_W)
              + (WIDE_W'(rlh4_ff) << HALF_W)
              + WIDE_W'(rll4_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en.adv[4]) begin
         hit5_ff <= hit4_ff;
         seg5_ff <= seg4_ff;
         sq5_ff  <= sq5_in;
         rhs5_ff <= rhs5_in;
      end
   end

   assign lhs6_in = sq5_ff[0] + sq5_ff[1] + sq5_ff[2];

   always_ff @(posedge clock) begin
      if (stage_en.adv[5]) begin
         hit6_ff <= hit5_ff;
         seg6_ff <= seg5_ff;
         lhs6_ff <= lhs6_in;
         rhs6_ff <= rhs5_ff;
      end
   end

   assign cut = hit6_ff || (seg6_ff && (lhs6_ff < rhs6_ff));

endmodule

FILE: rtl/spring_tear_proximity_test.sv
// Spring tear proximity test. Takes one item per cycle while the result side is not
// stalled and returns one result per item, in order: six arithmetic stages, the
// first loaded at the accepting edge, then an output register. The per-spring
// active bits sit in a RAM with one read port, used at acceptance, and one write
// port, used by the clearing pass and when a cut leaves the last stage; a cut is
// also broadcast to younger items of the same spring still in flight, so repeated
// indexes run at full rate too. After reset a clearing pass sets every active bit,
// one address at a time, during which no item is accepted. tear_radius is sampled
// when an item moves from the first stage to the second, so write it only while no
// item is in flight.
// Depends on stp_pkg, stp_ram, stp_geom, stp_wide and assert_macros.svh.
`include "assert_macros.svh"

module spring_tear_proximity_test import stp_pkg::*; #(
   parameter int SPRING_COUNT = 4096
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COORD_W-1:0]  req_center_x,
   input  logic [COORD_W-1:0]  req_center_y,
   input  logic [COORD_W-1:0]  req_center_z,
   input  logic [COORD_W-1:0]  req_end_a_x,
   input  logic [COORD_W-1:0]  req_end_a_y,
   input  logic [COORD_W-1:0]  req_end_a_z,
   input  logic [COORD_W-1:0]  req_end_b_x,
   input  logic [COORD_W-1:0]  req_end_b_y,
   input  logic [COORD_W-1:0]  req_end_b_z,
   input  logic [IDX_W-1:0]    req_spring_index,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [IDX_W-1:0]    rsp_spring_id,
   output logic                rsp_cut_now,
   output logic                rsp_still_active,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam int AW = $clog2(SPRING_COUNT);
   localparam int IW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
   localparam int NB = STAGES - 1;

   // configuration
   logic [RAD_W-1:0] radius_ff, radius_in;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign radius_in  = (csr_wr && csr_paddr[CSR_AW-1] == REG_TEAR_RADIUS)
                       ? csr_pwdata[RAD_W-1:0] : radius_ff;
   assign csr_prdata = (csr_paddr[CSR_AW-1] == REG_TEAR_RADIUS)
                       ? CSR_DW'(radius_ff) : '0;

   // clearing pass
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_ff, clr_in;

   assign clearing_in = clearing_ff && (clr_ff != AW'(SPRING_COUNT - 1));
   assign clr_in      = clearing_ff ? clr_ff + 1'b1 : clr_ff;

   // pipeline control
   stage_en_type       stage_en;
   logic               en_out;
   logic               req_fire;
   logic [STAGES-1:0]  valid_ff, valid_in;

   logic               s1_rng_ff, s1_rng_in;
   logic               s1_kill_ff, s1_kill_in;
   logic [IDX_W-1:0]   s1_idx_ff, s1_idx_in;
   logic               s1_act;
   logic               ram_rdata;

   logic [IDX_W-1:0]   idx_ff [NB];
   logic [IDX_W-1:0]   idx_in [NB];
   logic               act_ff [NB];
   logic               act_in [NB];
   logic [IDX_W-1:0]   src_idx;
   logic               src_act;

   logic               cut;
   logic               kill_v;
   logic [IDX_W-1:0]   kill_idx;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_id_ff;
   logic               rsp_cut_ff, rsp_act_ff;

   assign en_out = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stage_en.adv[STAGES-1] = !valid_ff[STAGES-1] || en_out;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en.adv[k] = !valid_ff[k] || stage_en.adv[k+1];
      end
   end

   assign req_ready = stage_en.adv[0] && !clearing_ff;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      valid_in[0] = stage_en.adv[0] ? req_fire : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = stage_en.adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   // a cut leaving the last stage
   assign kill_v   = valid_ff[STAGES-1] && en_out && act_ff[NB-1] && cut;
   assign kill_idx = idx_ff[NB-1];

   always_comb begin
      if (stage_en.adv[0]) begin
         s1_idx_in  = req_spring_index;
         s1_rng_in  = IW'(req_spring_index) < IW'(SPRING_COUNT);
         s1_kill_in = kill_v && (req_spring_index == kill_idx);
      end else begin
         s1_idx_in  = s1_idx_ff;
         s1_rng_in  = s1_rng_ff;
         s1_kill_in = s1_kill_ff || (kill_v && (s1_idx_ff == kill_idx));
      end
   end

   assign s1_act = ram_rdata && s1_rng_ff && !s1_kill_ff;

   // younger items of a spring being cut lose their active bit on the way
   always_comb begin
      for (int k = 0; k < NB; k++) begin
         if (stage_en.adv[k+1]) begin
            if (k == 0) begin
               src_idx = s1_idx_ff;
               src_act = s1_act;
            end else begin
               src_idx = idx_ff[k-1];
               src_act = act_ff[k-1];
            end
         end else begin
            src_idx = idx_ff[k];
            src_act = act_ff[k];
         end
         idx_in[k] = src_idx;
         act_in[k] = src_act && !(kill_v && (src_idx == kill_idx));
      end
   end

   assign rsp_valid_in = en_out ? valid_ff[STAGES-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= TEAR_RADIUS_RESET;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radius_ff    <= radius_in;
         clearing_ff  <= clearing_in;
         clr_ff       <= clr_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= s1_idx_in;
      s1_rng_ff  <= s1_rng_in;
      s1_kill_ff <= s1_kill_in;
      idx_ff     <= idx_in;
      act_ff     <= act_in;
      if (en_out) begin
         rsp_id_ff  <= idx_ff[NB-1];
         rsp_cut_ff <= act_ff[NB-1] && cut;
         rsp_act_ff <= act_ff[NB-1] && !cut;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_spring_id    = rsp_id_ff;
   assign rsp_cut_now      = rsp_cut_ff;
   assign rsp_still_active = rsp_act_ff;

   // active bit store
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [IW-1:0] req_idx_ext;
   logic [IW-1:0] kill_idx_ext;

   assign req_idx_ext  = IW'(req_spring_index);
   assign kill_idx_ext = IW'(kill_idx);
   assign ram_we       = clearing_ff || kill_v;
   assign ram_waddr    = clearing_ff ? clr_ff : kill_idx_ext[AW-1:0];

   stp_ram #(
      .WIDTH (1),
      .DEPTH (SPRING_COUNT)
   ) u_active (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (clearing_ff),
      .rd_en   (req_fire),
      .rd_addr (req_idx_ext[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // datapath
   geom_type geom;

   stp_geom u_geom (
      .clock       (clock),
      .stage_en    (stage_en),
      .c_pos       ({req_center_z, req_center_y, req_center_x}),
      .a_pos       ({req_end_a_z, req_end_a_y, req_end_a_x}),
      .b_pos       ({req_end_b_z, req_end_b_y, req_end_b_x}),
      .tear_radius (radius_ff),
      .geom        (geom)
   );

   stp_wide u_wide (
      .clock    (clock),
      .stage_en (stage_en),
      .geom     (geom),
      .cut      (cut)
   );

   `CHK_NEVER(a_no_accept_clear, clock, reset, clearing_ff && req_ready, "item accepted while clearing")
   `CHK_ASSERT(a_cut_inactive, clock, reset, rsp_valid && rsp_cut_now |-> !rsp_still_active, "cut spring reported active")
   `CHK_ASSERT(a_kill_clean, clock, reset, kill_v |-> !clearing_ff && valid_ff[STAGES-1], "cut write without item")

endmodule
